// ===== rtl/gbc_pkg.sv =====
// types, constants and round functions for the gost block cipher unit
// no dependencies; imported by every other file of the block

package gbc_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] key_sched_t;

	// control bits that travel down the round pipeline with each block
	typedef struct packed {
		logic valid;
		logic kind;
	} ctl_t;

	// one finished block on its way to the result channel
	typedef struct packed {
		word_t out_lo;
		word_t out_hi;
	} out_blk_t;

	localparam int NumRounds = 32;

	// configuration register indexes
	localparam logic [2:0] REG_KEY01 = 3'd0;
	localparam logic [2:0] REG_KEY23 = 3'd1;
	localparam logic [2:0] REG_KEY45 = 3'd2;
	localparam logic [2:0] REG_KEY67 = 3'd3;
	localparam logic [2:0] REG_SBOX  = 3'd4;

	// direction codes
	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	// packed s-box sets: byte 4*v + r holds row 2r (high nibble) and row 2r+1 (low nibble)
	localparam logic [7:0] SBOX_TAB [2][64] = '{
		'{8'h4E, 8'h57, 8'h64, 8'hD1, 8'hAB, 8'h8D, 8'hCB, 8'hBF,
		  8'h94, 8'h1A, 8'h7A, 8'h4D, 8'h2C, 8'hD1, 8'h10, 8'h10,
		  8'hD6, 8'hA0, 8'h57, 8'h35, 8'h8D, 8'h38, 8'hF2, 8'hF7,
		  8'h0F, 8'h49, 8'hD1, 8'h5A, 8'hEA, 8'h2F, 8'h8D, 8'h94,
		  8'h62, 8'hEE, 8'h43, 8'h09, 8'hB3, 8'hF4, 8'hA6, 8'hA2,
		  8'h18, 8'hC6, 8'h98, 8'hE3, 8'hC1, 8'h7C, 8'hE5, 8'h7E,
		  8'h70, 8'h6B, 8'h09, 8'h66, 8'hF7, 8'h02, 8'h3C, 8'h8B,
		  8'h55, 8'h95, 8'hBF, 8'h28, 8'h39, 8'hB3, 8'h2E, 8'hCC},
		'{8'hA5, 8'h74, 8'h77, 8'hD1, 8'h4F, 8'hFA, 8'h66, 8'hE3,
		  8'h54, 8'hC7, 8'h42, 8'h4A, 8'h60, 8'hEC, 8'hB4, 8'h19,
		  8'h82, 8'h90, 8'h9D, 8'h75, 8'h1D, 8'h4F, 8'hC9, 8'h0B,
		  8'h3B, 8'h12, 8'h2F, 8'h54, 8'h79, 8'h08, 8'hA0, 8'hAF,
		  8'hD1, 8'h3E, 8'h1A, 8'h38, 8'hC7, 8'hB1, 8'h81, 8'hC6,
		  8'hE6, 8'h56, 8'h05, 8'h87, 8'h03, 8'h25, 8'hEB, 8'hFE,
		  8'h9C, 8'h6D, 8'hF8, 8'h6D, 8'h2E, 8'hAB, 8'hDE, 8'h20,
		  8'hBA, 8'h89, 8'h3C, 8'h92, 8'hF8, 8'hD3, 8'h53, 8'hBC}
	};

	// substitute all eight nibbles, nibble i through row i
	function automatic word_t sbox_sub(logic set, word_t t);
		logic [7:0] b;
		logic [3:0] v;
		logic [1:0] r;
		word_t      s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			v = t[4*i +: 4];
			r = 2'(i >> 1);
			b = SBOX_TAB[set][{v, r}];
			s[4*i +: 4] = (i % 2 == 1) ? b[3:0] : b[7:4];
		end
		return s;
	endfunction

	// full round function: key add, substitution, rotate left by 11
	function automatic word_t round_fn(logic set, word_t half, word_t key);
		word_t s;
		s = sbox_sub(set, half + key);
		return {s[20:0], s[31:21]};
	endfunction

	// key word used by half-round k
	function automatic logic [2:0] key_idx(logic [4:0] k, logic kind);
		logic fwd;
		fwd = (kind == KIND_DECRYPT) ? (k < 5'd8) : (k < 5'd24);
		return fwd ? k[2:0] : ~k[2:0];
	endfunction

endpackage

// ===== rtl/gbc_in_if.sv =====
// block input channel: valid/ready handshake with direction and two halves
// depends on gbc_pkg for the word type

interface gbc_in_if import gbc_pkg::*;;
	logic  valid;
	logic  ready;
	logic  kind;
	word_t word_lo;
	word_t word_hi;

	modport source (output valid, output kind, output word_lo, output word_hi, input ready);
	modport sink   (input valid, input kind, input word_lo, input word_hi, output ready);
endinterface

// ===== rtl/gbc_out_if.sv =====
// result channel: valid/ready handshake with the two swapped output halves
// depends on gbc_pkg for the word type

interface gbc_out_if import gbc_pkg::*;;
	logic  valid;
	logic  ready;
	word_t out_lo;
	word_t out_hi;

	modport source (output valid, output out_lo, output out_hi, input ready);
	modport sink   (input valid, input out_lo, input out_hi, output ready);
endinterface

// ===== rtl/gbc_round.sv =====
// one feistel half-round of the cipher followed by its pipeline register
// depends on gbc_pkg for types and the round function

module gbc_round import gbc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       sbox_set,
	input  key_sched_t keys,
	input  ctl_t       ctl_i,
	input  word_t      n1_i,
	input  word_t      n2_i,
	output ctl_t       ctl_o,
	output word_t      n1_o,
	output word_t      n2_o
);

	localparam logic [4:0] K = 5'(STAGE);

	ctl_t  ctl_s1;
	word_t n1_s1;
	word_t n2_s1;
	word_t f;
	word_t n1_nxt;
	word_t n2_nxt;

	// even half-rounds update n2 from n1, odd ones update n1 from n2
	always_comb begin
		if (K[0]) begin
			f      = round_fn(sbox_set, n2_i, keys[key_idx(K, ctl_i.kind)]);
			n1_nxt = n1_i ^ f;
			n2_nxt = n2_i;
		end else begin
			f      = round_fn(sbox_set, n1_i, keys[key_idx(K, ctl_i.kind)]);
			n1_nxt = n1_i;
			n2_nxt = n2_i ^ f;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			n1_s1 <= n1_nxt;
			n2_s1 <= n2_nxt;
		end
	end

	assign ctl_o = ctl_s1;
	assign n1_o  = n1_s1;
	assign n2_o  = n2_s1;

endmodule

// ===== rtl/gbc_outbuf.sv =====
// output register with one skid entry behind the round pipeline
// depends on gbc_pkg and the gbc_out_if channel

module gbc_outbuf import gbc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  out_blk_t       blk,
	output logic           full,
	gbc_out_if.source      out_ch
);

	logic     out_valid_q;
	out_blk_t out_q;
	logic     skid_valid_q;
	out_blk_t skid_q;
	logic     pop;

	assign pop = out_valid_q && out_ch.ready;

	// head/skid control; push only arrives while the skid is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// head/skid data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= blk;
			end else begin
				out_q <= blk;
			end
		end
	end

	assign full          = skid_valid_q;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.out_lo = out_q.out_lo;
	assign out_ch.out_hi = out_q.out_hi;

endmodule

// ===== rtl/gost_block_cipher_unit.sv =====
// top level of the gost 28147-89 block cipher: key registers, 32 round stages, output buffer
// depends on gbc_pkg, gbc_in_if, gbc_out_if, gbc_round and gbc_outbuf
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        kind, word_lo, word_hi
//  out_ch    out  valid/ready        out_lo, out_hi
//  cfg       in   cfg_we (no wait)   cfg_index[2:0], cfg_data[63:0]
//
// one block enters per cycle while in_ch.ready is high; 32 round stages, one half-round each,
// then the output register, which a block passes last before it is valid on out_ch.
// in_ch.ready comes from a register: it drops only while the skid entry holds a beat, and
// then the whole round pipeline holds still; no combinational path from out_ch to in_ch.
// reset clears the valid bits, the key words and the s-box select; no clearing pass.

module gost_block_cipher_unit import gbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	gbc_in_if.sink      in_ch,
	gbc_out_if.source   out_ch
);

	logic [63:0] key_q [4];
	logic        sbox_set_q;
	key_sched_t  keys;
	logic        en;
	logic        full;

	ctl_t  ctl   [NumRounds+1];
	word_t n1    [NumRounds+1];
	word_t n2    [NumRounds+1];

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			sbox_set_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY01: key_q[0] <= cfg_data;
				REG_KEY23: key_q[1] <= cfg_data;
				REG_KEY45: key_q[2] <= cfg_data;
				REG_KEY67: key_q[3] <= cfg_data;
				REG_SBOX:  sbox_set_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule words, low half first
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			keys[2*i]   = key_q[i][31:0];
			keys[2*i+1] = key_q[i][63:32];
		end
	end

	// pipeline advances whenever the skid entry is free
	assign en          = !full;
	assign in_ch.ready = en;

	assign ctl[0].valid = in_ch.valid;
	assign ctl[0].kind  = in_ch.kind;
	assign n1[0]        = in_ch.word_lo;
	assign n2[0]        = in_ch.word_hi;

	// round stages
	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		gbc_round #(.STAGE(g)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.sbox_set (sbox_set_q),
			.keys     (keys),
			.ctl_i    (ctl[g]),
			.n1_i     (n1[g]),
			.n2_i     (n2[g]),
			.ctl_o    (ctl[g+1]),
			.n1_o     (n1[g+1]),
			.n2_o     (n2[g+1])
		);
	end

	// output register and skid, halves swapped
	gbc_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ctl[NumRounds].valid && en),
		.blk    ('{out_lo: n2[NumRounds], out_hi: n1[NumRounds]}),
		.full   (full),
		.out_ch (out_ch)
	);

	// skid entry only fills behind an occupied output register
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> out_ch.valid)
		else $error("skid entry holds a beat while the output register is empty");

	// an accepted beat lands in the first round stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> ctl[1].valid)
		else $error("accepted beat missing from first round stage");

	// a stalled pipeline holds its last stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(ctl[NumRounds]) && $stable(n1[NumRounds]) && $stable(n2[NumRounds])))
		else $error("last round stage changed during a stall");

endmodule

// ===== tb/tb_gost_block_cipher_unit.sv =====
`timescale 1ns / 1ps
// testbench for gost_block_cipher_unit: drives blocks and key/s-box settings, checks every result
// depends on gbc_pkg, gbc_in_if, gbc_out_if and the rtl of the block

module tb_gost_block_cipher_unit import gbc_pkg::*;;

	// register indexes past the end of the map, writes there must do nothing
	localparam logic [2:0] REG_SPARE_5 = 3'd5;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam int MaxReported = 10;
	localparam int DrainCycles = 40;

	typedef struct packed {
		logic  kind;
		word_t lo;
		word_t hi;
	} blk_in_t;

	// directed blocks, run on the reset key; no cipher output is readable by eye,
	// so every row goes through the predictor
	localparam blk_in_t DIRECTED_ROWS [18] = '{
		'{KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
		'{KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000},
		'{KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{KIND_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
		'{KIND_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
		'{KIND_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA},
		'{KIND_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555},
		'{KIND_ENCRYPT, 32'h0000_0001, 32'h0000_0000},
		'{KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0001},
		'{KIND_DECRYPT, 32'h8000_0000, 32'h0000_0000},
		'{KIND_DECRYPT, 32'h0000_0000, 32'h8000_0000},
		'{KIND_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF},
		'{KIND_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567},
		'{KIND_ENCRYPT, 32'hFEDC_BA98, 32'h7654_3210},
		'{KIND_ENCRYPT, 32'h0000_0001, 32'h8000_0000},
		'{KIND_DECRYPT, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
		'{KIND_ENCRYPT, 32'h0F0F_0F0F, 32'hF0F0_F0F0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	gbc_in_if  in_ch ();
	gbc_out_if out_ch ();

	gost_block_cipher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow copy of the configuration as the block should hold it
	logic [63:0] key_reg [4];
	logic        sbox_sel;

	out_blk_t pending_blocks [$];

	int  error_cnt;
	int  blocks_sent;
	int  blocks_checked;
	int  setting_cnt;
	int  sink_hold;
	bit  src_idle_en;
	bit  sink_stall_en;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// one gost half-round: key add, nibble substitution, rotate left by 11
	function automatic word_t gost_half(logic set, word_t half, word_t key);
		word_t      sum;
		word_t      sub;
		logic [7:0] pair;
		sum = half + key;
		for (int n = 0; n < 8; n++) begin
			pair = SBOX_TAB[set][4 * int'(sum[4*n +: 4]) + n / 2];
			sub[4*n +: 4] = (n % 2 == 1) ? pair[3:0] : pair[7:4];
		end
		return (sub << 11) | (sub >> 21);
	endfunction

	function automatic word_t key_word(int i);
		return (i % 2 == 1) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
	endfunction

	// full 32 half-round cipher on the current key and s-box set
	function automatic out_blk_t gost_crypt(logic kind, word_t lo, word_t hi);
		word_t    n1;
		word_t    n2;
		logic     fwd;
		int       ki;
		out_blk_t blk;
		n1 = lo;
		n2 = hi;
		for (int k = 0; k < 32; k++) begin
			fwd = (kind == KIND_DECRYPT) ? (k < 8) : (k < 24);
			ki = fwd ? (k % 8) : (7 - k % 8);
			if (k % 2 == 0)
				n2 ^= gost_half(sbox_sel, n1, key_word(ki));
			else
				n1 ^= gost_half(sbox_sel, n2, key_word(ki));
		end
		blk.out_lo = n2;
		blk.out_hi = n1;
		return blk;
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic log_error(string msg);
		error_cnt++;
		if (error_cnt <= MaxReported)
			$display("error at %0t: %s", $realtime, msg);
	endtask

	// register write, only issued while the block is idle
	task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx <= REG_KEY67)
			key_reg[idx[1:0]] = data;
		else if (idx == REG_SBOX)
			sbox_sel = data[0];
	endtask

	task automatic apply_setting(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
			logic [63:0] k67, logic [63:0] sbox_data);
		cfg_write(REG_KEY01, k01);
		cfg_write(REG_KEY23, k23);
		cfg_write(REG_KEY45, k45);
		cfg_write(REG_KEY67, k67);
		cfg_write(REG_SBOX, sbox_data);
		setting_cnt++;
	endtask

	// present one block and hold it until the beat is taken
	task automatic push_block(logic kind, word_t lo, word_t hi);
		int gap;
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_ch.valid   <= 1'b0;
			in_ch.kind    <= 1'($urandom_range(0, 1));
			in_ch.word_lo <= $urandom;
			in_ch.word_hi <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.kind    <= kind;
		in_ch.word_lo <= lo;
		in_ch.word_hi <= hi;
		do @(posedge clk); while (!in_ch.ready);
		pending_blocks.push_back(gost_crypt(kind, lo, hi));
		blocks_sent++;
	endtask

	task automatic stop_stream();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic wait_results();
		while (pending_blocks.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			push_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
		stop_stream();
		wait_results();
	endtask

	// result side back-pressure in short bursts
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			out_ch.ready <= 1'b0;
		end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
			sink_hold = $urandom_range(1, 3) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest predicted block
	always @(posedge clk) begin
		out_blk_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_blocks.size() == 0) begin
				log_error($sformatf("result %h_%h with no block outstanding",
					out_ch.out_hi, out_ch.out_lo));
			end else begin
				want = pending_blocks.pop_front();
				blocks_checked++;
				if (out_ch.out_lo !== want.out_lo)
					log_error($sformatf("out_lo expected %h got %h", want.out_lo, out_ch.out_lo));
				if (out_ch.out_hi !== want.out_hi)
					log_error($sformatf("out_hi expected %h got %h", want.out_hi, out_ch.out_hi));
			end
		end
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.kind    = KIND_ENCRYPT;
		in_ch.word_lo = '0;
		in_ch.word_hi = '0;
		out_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_KEY01;
		cfg_data      = '0;
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		sbox_sel       = 1'b0;
		error_cnt      = 0;
		blocks_sent    = 0;
		blocks_checked = 0;
		setting_cnt    = 1;
		sink_hold      = 0;
		src_idle_en    = 1'b1;
		sink_stall_en  = 1'b1;

		// reset
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed blocks on the all-zero reset key and the test s-box set
		foreach (DIRECTED_ROWS[r])
			push_block(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].lo, DIRECTED_ROWS[r].hi);
		stop_stream();
		wait_results();

		// all-ones key, second s-box set selected with every data bit set
		apply_setting('1, '1, '1, '1, '1);
		run_random(200);

		// random key, s-box bit cleared with upper bits set, writes past the map ignored
		apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFE);
		cfg_write(REG_SPARE_5, '1);
		cfg_write(REG_SPARE_6, {$urandom, $urandom});
		cfg_write(REG_SPARE_7, '1);
		run_random(200);

		// stretch with no idling on either side
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 64'd1);
		run_random(200);

		// half-word extremes in the key to stress the modular add
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
		apply_setting(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
			64'h8000_0000_7FFF_FFFF, 64'h0000_0001_FFFF_FFFF, 64'd0);
		run_random(200);

		// random key and set, only one side idles
		sink_stall_en = 1'b0;
		apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_random(120);
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b1;
		run_random(120);

		// last part, full rate on both sides
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_random(210);

		// let any stray beat show up
		repeat (DrainCycles) @(posedge clk);
		if (pending_blocks.size() != 0)
			log_error($sformatf("%0d blocks never came out", pending_blocks.size()));

		$display("%0d blocks sent over %0d key and s-box settings, %0d results compared",
			blocks_sent, setting_cnt, blocks_checked);
		$display("%0d errors seen", error_cnt);
		if (error_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
